FILE: hw/rtl/utra_pkg.sv
// Package: shared types, constants and helpers for the radix ASCII converter.
`timescale 1ns / 1ps

package utra_pkg;

  localparam int NUMBER_W = 32;
  localparam int BASE_W   = 6;
  localparam int CHAR_W   = 7;

  // Quotient bits retired per divider cycle.
  localparam int DIV_STEP_BITS = 4;

  localparam logic [BASE_W-1:0] BASE_MIN = 6'd2;
  localparam logic [BASE_W-1:0] BASE_MAX = 6'd36;

  localparam logic [CHAR_W-1:0] CH_ZERO       = 7'h30;  // '0'
  localparam logic [CHAR_W-1:0] CH_NINE       = 7'h39;  // '9'
  localparam logic [CHAR_W-1:0] CH_UPPER_A    = 7'h41;  // 'A'
  localparam logic [CHAR_W-1:0] CH_UPPER_Z    = 7'h5A;  // 'Z'
  localparam logic [CHAR_W-1:0] CH_ALPHA_BASE = 7'h37;  // 'A' - 10
  localparam logic [CHAR_W-1:0] CH_NONE       = 7'h00;

  localparam logic [BASE_W-1:0] DEC_DIGITS = 6'd10;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_READ,
    S_EMIT,
    S_EMPTY
  } utra_state_t;

  function automatic logic base_ok(input logic [BASE_W-1:0] b);
    return (b >= BASE_MIN) && (b <= BASE_MAX);
  endfunction

  function automatic logic [CHAR_W-1:0] digit_to_char(input logic [BASE_W-1:0] d);
    logic [CHAR_W-1:0] dx;
    dx = {1'b0, d};
    if (d < DEC_DIGITS) begin
      return CH_ZERO + dx;
    end
    return CH_ALPHA_BASE + dx;
  endfunction

endpackage

FILE: hw/rtl/utra_if.sv
// Interfaces: valid/ready channels for the input value and the output characters.
`timescale 1ns / 1ps

interface utra_in_if;
  import utra_pkg::*;

  logic                valid;
  logic                ready;
  logic [NUMBER_W-1:0] number_in;
  logic [BASE_W-1:0]   base;

  modport source (output valid, output number_in, output base, input ready);
  modport sink   (input valid, input number_in, input base, output ready);
endinterface

interface utra_out_if;
  import utra_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              last_char;
  logic              empty_result;

  modport source (output valid, output char_code, output last_char, output empty_result,
                  input ready);
  modport sink   (input valid, input char_code, input last_char, input empty_result,
                  output ready);
endinterface

FILE: hw/rtl/unsigned_to_radix_ascii.sv
// Top level: unsigned value to ASCII digit string in radix 2..36.
`timescale 1ns / 1ps
//
// Usage
//   in_chan  : one transfer carries number_in (low VALUE_BITS bits used) and base.
//   out_chan : one transfer per digit character, most significant first;
//              last_char marks the final one. A base outside 2..36 yields a single
//              transfer with empty_result=1, last_char=1, char_code=0.
//   in_chan.ready is high only while idle: one conversion at a time.
//
// Sequence, STEPS = ceil(VALUE_BITS/4), D = number of digits:
//   divide : one shared 4-bit-per-cycle restoring divider produces each of the D
//            digits (quotient and remainder), retiring STEPS*4 quotient bits each.
//   emit   : per character, a digit store read into rd_data_r, then the offer on out_chan.
//   invalid base: the result is offered the cycle after the input transfer.
//
// Reset (synchronous, rst_n low) returns the sequencer to idle and drops
// out_chan.valid. The digit store is not cleared; every entry is written
// before it is read. A stalled receiver simply holds the current character
// on out_chan until ready; nothing is lost.
module unsigned_to_radix_ascii #(
  parameter int VALUE_BITS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  utra_in_if.sink    in_chan,
  utra_out_if.source out_chan
);
  import utra_pkg::*;

  localparam int STEPS = (VALUE_BITS + DIV_STEP_BITS - 1) / DIV_STEP_BITS;
  localparam int PW    = STEPS * DIV_STEP_BITS;   // padded dividend width
  localparam int SW    = $clog2(STEPS);           // divider step counter
  localparam int CW    = $clog2(VALUE_BITS + 1);  // digit count
  localparam int AW    = $clog2(VALUE_BITS);      // digit store address

  utra_state_t       state_r, state_nxt;
  logic [PW-1:0]     quo_r, quo_nxt;       // dividend in, quotient out
  logic [BASE_W-1:0] rem_r, rem_nxt;
  logic [BASE_W-1:0] base_r, base_nxt;
  logic [SW-1:0]     step_r, step_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [BASE_W-1:0] rd_data_r;

  logic [BASE_W-1:0] digit_mem [VALUE_BITS];

  logic              in_xfer, out_xfer;
  logic              div_done;
  logic [PW-1:0]     div_quo;
  logic [BASE_W-1:0] div_rem;
  logic [PW-1:0]     value_in;
  logic [63:0]       num_ext;
  logic [CW-1:0]     cnt_dec;
  logic              mem_we, mem_re;
  logic [AW-1:0]     wr_addr, rd_addr;

  assign in_xfer  = in_chan.valid && in_chan.ready;
  assign out_xfer = out_chan.valid && out_chan.ready;
  assign cnt_dec  = cnt_r - 1'b1;
  assign wr_addr  = cnt_r[AW-1:0];
  assign rd_addr  = cnt_dec[AW-1:0];
  assign div_done = (state_r == S_DIV) && (step_r == SW'(STEPS - 1));
  assign mem_we   = div_done;
  assign mem_re   = (state_r == S_READ);

  // Mask the input down to VALUE_BITS and zero-pad to the divider width.
  assign num_ext = {{(64 - NUMBER_W){1'b0}}, in_chan.number_in};
  always_comb begin
    value_in = '0;
    for (int i = 0; i < PW; i++) begin
      if (i < VALUE_BITS) begin
        value_in[i] = num_ext[i];
      end
    end
  end

  // Shared divider: DIV_STEP_BITS restoring steps on a narrow remainder.
  always_comb begin
    logic [BASE_W:0] trial;
    logic [BASE_W:0] divisor;
    divisor = {1'b0, base_r};
    div_quo = quo_r;
    div_rem = rem_r;
    for (int k = 0; k < DIV_STEP_BITS; k++) begin
      trial   = {div_rem, div_quo[PW-1]};
      div_quo = {div_quo[PW-2:0], 1'b0};
      if (trial >= divisor) begin
        trial      = trial - divisor;
        div_quo[0] = 1'b1;
      end
      div_rem = trial[BASE_W-1:0];
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt = base_ok(in_chan.base) ? S_DIV : S_EMPTY;
        end
      end
      S_DIV: begin
        if (div_done && (div_quo == '0)) begin
          state_nxt = S_READ;
        end
      end
      S_READ: state_nxt = S_EMIT;
      S_EMIT: begin
        if (out_xfer) begin
          state_nxt = (cnt_r == '0) ? S_IDLE : S_READ;
        end
      end
      S_EMPTY: begin
        if (out_xfer) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Handshake and payload
  always_comb begin
    in_chan.ready         = 1'b0;
    out_chan.valid        = 1'b0;
    out_chan.char_code    = CH_NONE;
    out_chan.last_char    = 1'b0;
    out_chan.empty_result = 1'b0;
    unique case (state_r)
      S_IDLE: in_chan.ready = 1'b1;
      S_DIV, S_READ: ;
      S_EMIT: begin
        out_chan.valid     = 1'b1;
        out_chan.char_code = digit_to_char(rd_data_r);
        out_chan.last_char = (cnt_r == '0);
      end
      S_EMPTY: begin
        out_chan.valid        = 1'b1;
        out_chan.last_char    = 1'b1;
        out_chan.empty_result = 1'b1;
      end
      default: ;
    endcase
  end

  // Datapath next values
  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    base_nxt = base_r;
    step_nxt = step_r;
    cnt_nxt  = cnt_r;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          quo_nxt  = value_in;
          rem_nxt  = '0;
          base_nxt = in_chan.base;
          step_nxt = '0;
          cnt_nxt  = '0;
        end
      end
      S_DIV: begin
        quo_nxt = div_quo;
        if (div_done) begin
          // digit stored this cycle; restart on the quotient
          rem_nxt  = '0;
          step_nxt = '0;
          cnt_nxt  = cnt_r + 1'b1;
        end else begin
          rem_nxt  = div_rem;
          step_nxt = step_r + 1'b1;
        end
      end
      S_READ: cnt_nxt = cnt_dec;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    base_r <= base_nxt;
  end

  // Digit store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      digit_mem[wr_addr] <= div_rem;
    end
    if (mem_re) begin
      rd_data_r <= digit_mem[rd_addr];
    end
  end

endmodule

FILE: hw/rtl/utra_checker.sv
// Checker: port-level properties of the radix ASCII converter, bound to the top level.
`timescale 1ns / 1ps

module utra_checker (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [utra_pkg::CHAR_W-1:0] char_code,
  input logic                   last_char,
  input logic                   empty_result
);
  import utra_pkg::*;

  // A stalled character stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(char_code) && $stable(last_char)
                                && $stable(empty_result))
    else $error("output changed while stalled");

  // No new input while a character is on offer.
  a_busy_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input ready while output pending");

  // After an input transfer the block is busy.
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after input transfer");

  // Empty result is a single terminating record with no character.
  a_empty_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && empty_result |-> last_char && (char_code == CH_NONE))
    else $error("malformed empty result");

  // Real digits are 0-9 or A-Z.
  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !empty_result |->
      ((char_code >= CH_ZERO) && (char_code <= CH_NINE)) ||
      ((char_code >= CH_UPPER_A) && (char_code <= CH_UPPER_Z)))
    else $error("character outside digit set");

endmodule

bind unsigned_to_radix_ascii utra_checker u_utra_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_chan.valid),
  .in_ready     (in_chan.ready),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .char_code    (out_chan.char_code),
  .last_char    (out_chan.last_char),
  .empty_result (out_chan.empty_result)
);
